@@ src/md5_sh_pkg.sv @@
package md5_sh_pkg;

   localparam int WORD_W    = 32;
   localparam int BUF_WORDS = 16;
   localparam int BUF_AW    = $clog2(BUF_WORDS);
   localparam int STEP_W    = 6;
   localparam int FILL_W    = 6;
   localparam int COUNT_W   = 61;

   localparam logic [7:0] PAD_MARKER = 8'h80;

   localparam logic [3:0][WORD_W-1:0] H_INIT = '{
      32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
   };

   localparam logic [WORD_W-1:0] SINE_TABLE [0:63] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [4:0] ROT_TABLE [0:15] = '{
      5'd7, 5'd12, 5'd17, 5'd22,
      5'd5, 5'd9,  5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23,
      5'd6, 5'd10, 5'd15, 5'd21
   };

   function automatic logic [BUF_AW-1:0] msg_index(input logic [STEP_W-1:0] k);
      logic [3:0] j;
      logic [3:0] r;
      j = k[3:0];
      unique case (k[5:4])
         2'd0: r = j;
         2'd1: r = 4'(j * 4'd5 + 4'd1);
         2'd2: r = 4'(j * 4'd3 + 4'd5);
         2'd3: r = 4'(j * 4'd7);
      endcase
      return r;
   endfunction

   function automatic logic [4:0] rot_amount(input logic [STEP_W-1:0] k);
      return ROT_TABLE[{k[5:4], k[1:0]}];
   endfunction

   function automatic logic [WORD_W-1:0] rot_left(input logic [WORD_W-1:0] v,
                                                  input logic [4:0] s);
      logic [2*WORD_W-1:0] dbl;
      dbl = {v, v} << s;
      return dbl[2*WORD_W-1:WORD_W];
   endfunction

   function automatic logic [WORD_W-1:0] lane_mask(input logic [1:0] lane);
      logic [WORD_W-1:0] m;
      unique case (lane)
         2'd0: m = 32'h00000000;
         2'd1: m = 32'h000000ff;
         2'd2: m = 32'h0000ffff;
         2'd3: m = 32'h00ffffff;
      endcase
      return m;
   endfunction

endpackage

@@ src/md5_sh_if.sv @@
interface md5_sh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       end_of_message;

   modport source(output valid, data_byte, has_byte, end_of_message, input ready);
   modport sink(input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface md5_sh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [1:0]  word_index;
   logic        last_word;

   modport source(output valid, digest_word, word_index, last_word, input ready);
   modport sink(input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ src/md5_sh_ram.sv @@
module md5_sh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ src/md5_stream_hasher_core.sv @@
// md5 digest of a byte stream, one optional byte per request beat
// req channel: data_byte with has_byte, end_of_message closes the message
// after the beat's byte; a beat with neither flag changes nothing
// rsp channel: four beats per message, digest words 0..3 in order,
// last_word set on word 3; each word's bytes are little-endian
// bytes are packed into 32-bit words of a 16-word buffer ram
// a byte beat that neither completes a block nor closes the message
// keeps req ready high; the byte that completes a block is followed by
// one ram read lead-in, 64 compression steps on one shared round unit,
// and one chaining-word add, with req ready low
// end of message: each padded block writes the buffer words left to
// fill, one per cycle, then is compressed; a second block of all 16 words
// follows when fewer than 9 bytes remain free; then the four digest beats
// req ready is low from the end-of-message beat until the last digest
// beat is taken; a stalled rsp beat holds its word until accepted
// reset (synchronous) restores the initial chaining words, empties the
// buffer and clears the byte count
module md5_stream_hasher_core (
   input logic          clock,
   input logic          reset,
   md5_sh_req_if.sink   req_bus,
   md5_sh_rsp_if.source rsp_bus
);
   import md5_sh_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PAD  = 3'd1;
   localparam logic [2:0] ST_PRE  = 3'd2;
   localparam logic [2:0] ST_STEP = 3'd3;
   localparam logic [2:0] ST_ADD  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   localparam logic [1:0] NX_IDLE = 2'd0;
   localparam logic [1:0] NX_PAD1 = 2'd1;
   localparam logic [1:0] NX_PAD2 = 2'd2;
   localparam logic [1:0] NX_OUT  = 2'd3;

   logic [2:0]               state_ff, state_in;
   logic [1:0]               next_ff, next_in;
   logic [FILL_W-1:0]        fill_ff, fill_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic [WORD_W-1:0]        acc_ff, acc_in;
   logic [BUF_AW-1:0]        pad_addr_ff, pad_addr_in;
   logic                     pad_marker_ff, pad_marker_in;
   logic                     pad_len_ff, pad_len_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [WORD_W-1:0]        a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   logic [3:0][WORD_W-1:0]   h_ff, h_in;
   logic [1:0]               out_idx_ff, out_idx_in;

   logic                     ram_wr_en;
   logic [BUF_AW-1:0]        ram_wr_addr;
   logic [WORD_W-1:0]        ram_wr_data;
   logic [BUF_AW-1:0]        ram_rd_addr;
   logic [WORD_W-1:0]        ram_rd_data;

   logic                     req_take;
   logic [1:0]               lane;
   logic [FILL_W-1:0]        fill_next;
   logic [WORD_W-1:0]        byte_word;
   logic [WORD_W-1:0]        marker_word;
   logic [2*WORD_W-1:0]      bit_len;
   logic [WORD_W-1:0]        f_val;
   logic [WORD_W-1:0]        step_sum;
   logic [WORD_W-1:0]        b_new;

   md5_sh_ram #(
      .WIDTH(WORD_W),
      .DEPTH(BUF_WORDS)
   ) u_buf (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign req_take            = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid       = (state_ff == ST_OUT);
   assign rsp_bus.digest_word = h_ff[out_idx_ff];
   assign rsp_bus.word_index  = out_idx_ff;
   assign rsp_bus.last_word   = (out_idx_ff == 2'd3);

   assign lane        = fill_ff[1:0];
   assign fill_next   = req_bus.has_byte ? fill_ff + 6'd1 : fill_ff;
   assign byte_word   = (acc_ff & lane_mask(lane))
                      | ({24'd0, req_bus.data_byte} << {lane, 3'b000});
   assign marker_word = (acc_ff & lane_mask(lane))
                      | ({24'd0, PAD_MARKER} << {lane, 3'b000});
   assign bit_len     = {count_ff, 3'b000};

   assign ram_rd_addr = (state_ff == ST_PRE) ? msg_index(6'd0) : msg_index(step_ff + 6'd1);

   // one md5 step per cycle on the shared round unit
   always_comb begin
      unique case (step_ff[5:4])
         2'd0: f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1: f_val = (b_ff & d_ff) | (c_ff & ~d_ff);
         2'd2: f_val = b_ff ^ c_ff ^ d_ff;
         2'd3: f_val = c_ff ^ (b_ff | ~d_ff);
      endcase
      step_sum = a_ff + f_val + ram_rd_data + SINE_TABLE[step_ff];
      b_new    = b_ff + rot_left(step_sum, rot_amount(step_ff));
   end

   always_comb begin
      state_in      = state_ff;
      next_in       = next_ff;
      fill_in       = fill_ff;
      count_in      = count_ff;
      acc_in        = acc_ff;
      pad_addr_in   = pad_addr_ff;
      pad_marker_in = pad_marker_ff;
      pad_len_in    = pad_len_ff;
      step_in       = step_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      c_in          = c_ff;
      d_in          = d_ff;
      h_in          = h_ff;
      out_idx_in    = out_idx_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = pad_addr_ff;
      ram_wr_data   = 32'd0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_bus.has_byte) begin
                  acc_in   = byte_word;
                  fill_in  = fill_next;
                  count_in = count_ff + 61'd1;
                  if (lane == 2'd3) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = fill_ff[5:2];
                     ram_wr_data = byte_word;
                  end
               end
               if (req_bus.has_byte && fill_next == 6'd0) begin
                  state_in = ST_PRE;
                  next_in  = req_bus.end_of_message ? NX_PAD1 : NX_IDLE;
               end else if (req_bus.end_of_message) begin
                  state_in      = ST_PAD;
                  pad_addr_in   = fill_next[5:2];
                  pad_marker_in = 1'b1;
                  pad_len_in    = (fill_next < 6'd56);
               end
            end
         end
         ST_PAD: begin
            ram_wr_en = 1'b1;
            priority if (pad_marker_ff && pad_addr_ff == fill_ff[5:2]) begin
               ram_wr_data = marker_word;
            end else if (pad_len_ff && pad_addr_ff == 4'd14) begin
               ram_wr_data = bit_len[31:0];
            end else if (pad_len_ff && pad_addr_ff == 4'd15) begin
               ram_wr_data = bit_len[63:32];
            end else begin
               ram_wr_data = 32'd0;
            end
            if (pad_addr_ff == 4'd15) begin
               state_in = ST_PRE;
               next_in  = pad_len_ff ? NX_OUT : NX_PAD2;
            end else begin
               pad_addr_in = pad_addr_ff + 4'd1;
            end
         end
         ST_PRE: begin
            a_in     = h_ff[0];
            b_in     = h_ff[1];
            c_in     = h_ff[2];
            d_in     = h_ff[3];
            step_in  = 6'd0;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            a_in    = d_ff;
            d_in    = c_ff;
            c_in    = b_ff;
            b_in    = b_new;
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd63) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            h_in[0] = h_ff[0] + a_ff;
            h_in[1] = h_ff[1] + b_ff;
            h_in[2] = h_ff[2] + c_ff;
            h_in[3] = h_ff[3] + d_ff;
            unique case (next_ff)
               NX_IDLE: state_in = ST_IDLE;
               NX_PAD1: begin
                  state_in      = ST_PAD;
                  pad_addr_in   = 4'd0;
                  pad_marker_in = 1'b1;
                  pad_len_in    = 1'b1;
               end
               NX_PAD2: begin
                  state_in      = ST_PAD;
                  pad_addr_in   = 4'd0;
                  pad_marker_in = 1'b0;
                  pad_len_in    = 1'b1;
               end
               NX_OUT: begin
                  state_in   = ST_OUT;
                  out_idx_in = 2'd0;
               end
            endcase
         end
         ST_OUT: begin
            if (rsp_bus.ready) begin
               if (out_idx_ff == 2'd3) begin
                  h_in     = H_INIT;
                  fill_in  = 6'd0;
                  count_in = 61'd0;
                  state_in = ST_IDLE;
               end else begin
                  out_idx_in = out_idx_ff + 2'd1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         next_ff    <= NX_IDLE;
         fill_ff    <= '0;
         count_ff   <= '0;
         h_ff       <= H_INIT;
         out_idx_ff <= '0;
         step_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         next_ff    <= next_in;
         fill_ff    <= fill_in;
         count_ff   <= count_in;
         h_ff       <= h_in;
         out_idx_ff <= out_idx_in;
         step_ff    <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff        <= acc_in;
      pad_addr_ff   <= pad_addr_in;
      pad_marker_ff <= pad_marker_in;
      pad_len_ff    <= pad_len_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      c_ff          <= c_in;
      d_ff          <= d_in;
   end
endmodule

@@ sim/md5_digest_checker.sv @@
module md5_digest_checker (
   input  logic  clock,
   input  logic  reset,
   md5_sh_req_if req_mon,
   md5_sh_rsp_if rsp_mon,
   output int    fail_count,
   output int    words_pending
);

   typedef struct packed {
      logic [31:0] word;
      logic [1:0]  idx;
      logic        last;
   } digest_beat_type;

   localparam int SHIFT_AMT [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                     4, 11, 16, 23, 6, 10, 15, 21};

   logic [31:0]     sine_k [64];
   logic [31:0]     hash_chain [4];
   logic [7:0]      block_bytes [64];
   logic [5:0]      block_fill;
   logic [60:0]     message_len;
   digest_beat_type expected_words [$];

   initial begin
      real s;
      for (int k = 0; k < 64; k++) begin
         s = $sin(real'(k + 1));
         if (s < 0.0) begin
            s = -s;
         end
         sine_k[k] = 32'(longint'($floor(s * 4294967296.0)));
      end
   end

   function automatic void restart_chain();
      hash_chain[0] = 32'h67452301;
      hash_chain[1] = 32'hefcdab89;
      hash_chain[2] = 32'h98badcfe;
      hash_chain[3] = 32'h10325476;
      block_fill = '0;
      message_len = '0;
   endfunction

   function automatic void fold_block();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, f, t, sum;
      int          g, s;
      for (int k = 0; k < 16; k++) begin
         w[k] = {block_bytes[4*k+3], block_bytes[4*k+2], block_bytes[4*k+1], block_bytes[4*k]};
      end
      a = hash_chain[0];
      b = hash_chain[1];
      c = hash_chain[2];
      d = hash_chain[3];
      for (int k = 0; k < 64; k++) begin
         case (k / 16)
            0: begin
               f = (b & c) | (~b & d);
               g = k;
            end
            1: begin
               f = (b & d) | (c & ~d);
               g = (5 * k + 1) % 16;
            end
            2: begin
               f = b ^ c ^ d;
               g = (3 * k + 5) % 16;
            end
            default: begin
               f = c ^ (b | ~d);
               g = (7 * k) % 16;
            end
         endcase
         s = SHIFT_AMT[(k / 16) * 4 + k % 4];
         sum = a + f + w[g] + sine_k[k];
         t = d;
         d = c;
         c = b;
         b = b + ((sum << s) | (sum >> (32 - s)));
         a = t;
      end
      hash_chain[0] += a;
      hash_chain[1] += b;
      hash_chain[2] += c;
      hash_chain[3] += d;
   endfunction

   function automatic void hash_beat(logic [7:0] data, logic has_byte, logic eom);
      logic [63:0]     bit_len;
      digest_beat_type beat;
      if (has_byte) begin
         block_bytes[block_fill] = data;
         block_fill = block_fill + 6'd1;
         message_len = message_len + 61'd1;
         if (block_fill == 6'd0) begin
            fold_block();
         end
      end
      if (eom) begin
         block_bytes[block_fill] = 8'h80;
         for (int k = int'(block_fill) + 1; k < 64; k++) begin
            block_bytes[k] = 8'h00;
         end
         // no room left for the length, it goes in a block of its own
         if (block_fill >= 6'd56) begin
            fold_block();
            for (int k = 0; k < 64; k++) begin
               block_bytes[k] = 8'h00;
            end
         end
         bit_len = {message_len, 3'b000};
         for (int k = 0; k < 8; k++) begin
            block_bytes[56 + k] = bit_len[8*k +: 8];
         end
         fold_block();
         for (int k = 0; k < 4; k++) begin
            beat.word = hash_chain[k];
            beat.idx = 2'(k);
            beat.last = (k == 3);
            expected_words.push_back(beat);
         end
         restart_chain();
      end
   endfunction

   function automatic void report(string msg);
      if (fail_count < 10) begin
         $display("%s", msg);
      end
      fail_count++;
   endfunction

   always @(posedge clock) begin
      digest_beat_type want;
      if (reset) begin
         restart_chain();
         expected_words.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_words.size() == 0) begin
               report($sformatf("unexpected digest beat: word %h idx %0d last %0b",
                                rsp_mon.digest_word, rsp_mon.word_index, rsp_mon.last_word));
            end else begin
               want = expected_words.pop_front();
               if (rsp_mon.digest_word !== want.word || rsp_mon.word_index !== want.idx ||
                   rsp_mon.last_word !== want.last) begin
                  report($sformatf("digest beat mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                                   want.word, want.idx, want.last, rsp_mon.digest_word,
                                   rsp_mon.word_index, rsp_mon.last_word));
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            hash_beat(req_mon.data_byte, req_mon.has_byte, req_mon.end_of_message);
         end
      end
      words_pending = expected_words.size();
   end

endmodule

@@ sim/tb_md5_stream_hasher_core.sv @@
module tb_md5_stream_hasher_core;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 400;
   localparam int PHASE_BEATS    = 35;
   localparam int DRAIN_CYCLES   = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int fail_count;
   int words_pending;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_requests = 0;
   int beats_sent = 0;

   md5_sh_req_if req_bus ();
   md5_sh_rsp_if rsp_bus ();

   md5_stream_hasher_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   md5_digest_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .fail_count    (fail_count),
      .words_pending (words_pending)
   );

   always #5 clock = ~clock;

   // receiver side, with a long hold-off when one is requested
   initial begin
      int hold_seen;
      hold_seen = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            repeat (HOLD_CYCLES) begin
               rsp_bus.ready = 1'b0;
               @(negedge clock);
            end
         end
         rsp_bus.ready = ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("md5_stream_hasher_core verification failed");
      $finish;
   end

   task automatic send_beat(input logic [7:0] data, input logic has_byte, input logic eom);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.data_byte = data;
      req_bus.has_byte = has_byte;
      req_bus.end_of_message = eom;
      do @(posedge clock); while (!req_bus.ready);
      if (has_byte || eom) begin
         beats_sent++;
      end
      @(negedge clock);
   endtask

   task automatic send_message(input int len);
      logic eom_on_byte;
      eom_on_byte = (len > 0) && ($urandom_range(1) == 1);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(9) == 0) begin
            send_beat(8'($urandom), 1'b0, 1'b0);
         end
         send_beat(8'($urandom), 1'b1, eom_on_byte && (i == len - 1));
      end
      if (!eom_on_byte) begin
         send_beat(8'($urandom), 1'b0, 1'b1);
      end
   endtask

   function automatic int pick_length();
      int roll;
      roll = $urandom_range(99);
      if (roll < 45) begin
         return $urandom_range(8);
      end else if (roll < 75) begin
         return $urandom_range(40, 9);
      end
      // lengths around the padding and block boundaries
      case ($urandom_range(5))
         0: return 55;
         1: return 56;
         2: return 57;
         3: return 63;
         4: return 64;
         default: return 65;
      endcase
   endfunction

   task automatic run_phase(input int idle_pct, input int stall_pct);
      int start_beats;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      start_beats = beats_sent;
      while (beats_sent - start_beats < PHASE_BEATS) begin
         send_message(pick_length());
      end
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.data_byte = 8'h00;
      req_bus.has_byte = 1'b0;
      req_bus.end_of_message = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty message, ignored data, byte on the closing beat, split close
      send_beat(8'h00, 1'b0, 1'b1);
      send_beat(8'hff, 1'b0, 1'b0);
      send_beat(8'h00, 1'b1, 1'b0);
      send_beat(8'hff, 1'b1, 1'b1);
      send_beat(8'h61, 1'b1, 1'b0);
      send_beat(8'h5a, 1'b0, 1'b0);
      send_beat(8'h62, 1'b1, 1'b0);
      send_beat(8'h63, 1'b1, 1'b0);
      send_beat(8'h3c, 1'b0, 1'b1);

      // padding spill into a second block, then an exact full block
      send_message(56);
      send_message(64);

      // receiver holds off while further messages wait to be sent
      hold_requests++;
      send_message(3);
      send_message(5);
      send_message(2);

      run_phase(0, 0);
      run_phase(59, 0);
      run_phase(0, 59);
      run_phase(10, 10);

      req_bus.valid = 1'b0;
      while (words_pending != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && words_pending == 0) begin
         $display("md5_stream_hasher_core verification clean");
      end else begin
         $display("md5_stream_hasher_core verification failed");
      end
      $finish;
   end

endmodule
